FILE: rtl/tli_pkg.sv
// Shared types and constants of the table linear interpolator.
package tli_pkg;

   // Fixed field widths
   localparam int COMP_WIDTH       = 32;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int NUM_COMPS        = 6;
   localparam int TIME_W           = 32;
   localparam int LOAD_IDX_W       = 12;
   localparam int COUNT_W          = 13;
   localparam int TABLE_DEPTH_DEF  = 4096;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_START_TIME  = 2'd0,
      REG_TIME_STEP   = 2'd1,
      REG_ENTRY_COUNT = 2'd2
   } reg_index_type;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Six components of one state vector, radius first
   typedef logic [NUM_COMPS-1:0][COMP_WIDTH-1:0] vec_type;

   typedef struct packed {
      logic                           operation;
      logic [LOAD_IDX_W-1:0]          load_index;
      logic signed [COMP_WIDTH-1:0]   comp_radius;
      logic signed [COMP_WIDTH-1:0]   comp_angle;
      logic signed [COMP_WIDTH-1:0]   comp_height;
      logic signed [COMP_WIDTH-1:0]   comp_vel_radius;
      logic signed [COMP_WIDTH-1:0]   comp_vel_angle;
      logic signed [COMP_WIDTH-1:0]   comp_vel_height;
      logic [TIME_W-1:0]              query_time;
   } req_type;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0]   out_radius;
      logic signed [COMP_WIDTH-1:0]   out_angle;
      logic signed [COMP_WIDTH-1:0]   out_height;
      logic signed [COMP_WIDTH-1:0]   out_vel_radius;
      logic signed [COMP_WIDTH-1:0]   out_vel_angle;
      logic signed [COMP_WIDTH-1:0]   out_vel_height;
      logic                           index_clamped;
   } rsp_type;

endpackage

FILE: rtl/tli_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module tli_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [DEN_W-1:0]  den,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [DEN_W-1:0]  out_rem,
   output logic [SIDE_W-1:0] out_side
);

   logic [NUM_W-1:0]  v_ff;
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   logic [DEN_W-1:0]  rem_src [NUM_W];
   logic [NUM_W-1:0]  nq_src  [NUM_W];
   logic [SIDE_W-1:0] side_src [NUM_W];
   logic [DEN_W:0]    trial   [NUM_W];
   logic [DEN_W:0]    diff    [NUM_W];
   logic [NUM_W-1:0]  ge;
   logic [DEN_W-1:0]  rem_in  [NUM_W];
   logic [NUM_W-1:0]  nq_in   [NUM_W];

   // Per stage: shift in the next numerator bit, subtract when it fits
   always_comb begin
      for (int s = 0; s < NUM_W; s++) begin
         if (s == 0) begin
            rem_src[s]  = '0;
            nq_src[s]   = in_num;
            side_src[s] = in_side;
         end else begin
            rem_src[s]  = rem_ff[s-1];
            nq_src[s]   = nq_ff[s-1];
            side_src[s] = side_ff[s-1];
         end
         trial[s]  = {rem_src[s], nq_src[s][NUM_W-1]};
         diff[s]   = trial[s] - {1'b0, den};
         ge[s]     = (trial[s] >= {1'b0, den});
         rem_in[s] = ge[s] ? diff[s][DEN_W-1:0] : trial[s][DEN_W-1:0];
         nq_in[s]  = {nq_src[s][NUM_W-2:0], ge[s]};
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NUM_W-2:0], in_valid};
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NUM_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            nq_ff[s]   <= nq_in[s];
            side_ff[s] <= side_src[s];
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

FILE: rtl/table_linear_interpolator_unit.sv
// Top level of the table linear interpolator: config, pipeline, table, blend.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_data (load or query)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data (one per query)
//  csr     | in        | csr_psel / csr_penable | start_time, time_step, entry_count
//
// One request per cycle unless a stalled result holds the pipeline. The two
// bit-serial dividers (32 and 49 stages) make up most of the pipeline depth.
// Loads write the table at the stage where queries read it, so order holds.
// Reset clears all valid bits and the configuration registers; the table is not cleared.
// A stalled result freezes the whole pipeline and stalls the request side.
module table_linear_interpolator_unit #(
   parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tli_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tli_pkg::rsp_type                rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tli_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tli_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tli_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import tli_pkg::*;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW     = COMP_WIDTH;
   localparam int WF     = WEIGHT_FRAC_BITS;
   localparam int WM_W   = TIME_W + WF + 1;
   localparam int WL_W   = (WM_W + 1) / 2;
   localparam int WH_W   = WM_W - WL_W;
   localparam int PROD_W = CW + WM_W + 1;
   localparam int MR_W   = PROD_W - WF;
   localparam int SUM_W  = CW + 3;

   localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (WF - 1);
   localparam logic [SUM_W-1:0]  SUM_MAX = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic [SUM_W-1:0]  SUM_MIN = {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic [CW-1:0]     C_MAX   = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0]     C_MIN   = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic                  op;
      logic                  neg;
      logic [TIME_W-1:0]     dmag;
      logic [LOAD_IDX_W-1:0] load_index;
      vec_type               vec;
   } side1_type;

   typedef struct packed {
      logic                  op;
      logic                  wneg;
      logic                  clamped;
      logic [IDX_W-1:0]      idx;
      logic [LOAD_IDX_W-1:0] load_index;
      vec_type               vec;
   } side2_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [TIME_W-1:0]  start_ff;
   logic [TIME_W-1:0]  step_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               csr_write;
   reg_index_type      csr_idx;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         step_ff  <= TIME_W'(1);
         count_ff <= COUNT_W'(2);
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_START_TIME:  start_ff <= csr_pwdata[TIME_W-1:0];
            REG_TIME_STEP:   step_ff  <= csr_pwdata[TIME_W-1:0];
            REG_ENTRY_COUNT: count_ff <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_START_TIME:  csr_prdata = CSR_DATA_W'(start_ff);
         REG_TIME_STEP:   csr_prdata = CSR_DATA_W'(step_ff);
         REG_ENTRY_COUNT: csr_prdata = CSR_DATA_W'(count_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Derived settings: step never zero, last segment index and its base time
   logic [TIME_W-1:0] step_eff_ff;
   logic [IDX_W-1:0]  hiidx_ff;
   logic [TIME_W-1:0] hi_base_ff;
   logic [31:0]       count32;
   logic [31:0]       count_clamp;

   always_comb begin
      count32 = 32'(count_ff);
      if (count32 < 32'd2) begin
         count_clamp = 32'd2;
      end else if (count32 > 32'(TABLE_DEPTH)) begin
         count_clamp = 32'(TABLE_DEPTH);
      end else begin
         count_clamp = count32;
      end
   end

   always_ff @(posedge clock) begin
      step_eff_ff <= (step_ff == '0) ? TIME_W'(1) : step_ff;
      hiidx_ff    <= IDX_W'(count_clamp - 32'd2);
      hi_base_ff  <= TIME_W'(hiidx_ff * step_eff_ff);
   end

   // ---------------------------------------------------------------------
   // Flow control: the whole pipeline moves when the result slot frees
   // ---------------------------------------------------------------------
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic    s0_valid_ff;
   req_type s0_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_req_ff <= req_data;
      end
   end

   // Signed offset from table start, as sign and magnitude
   logic [TIME_W:0]   off_fwd;
   logic [TIME_W-1:0] off_bwd;
   side1_type         side1_in;

   always_comb begin
      off_fwd = {1'b0, s0_req_ff.query_time} - {1'b0, start_ff};
      off_bwd = start_ff - s0_req_ff.query_time;
      side1_in.op         = s0_req_ff.operation;
      side1_in.neg        = off_fwd[TIME_W];
      side1_in.dmag       = off_fwd[TIME_W] ? off_bwd : off_fwd[TIME_W-1:0];
      side1_in.load_index = s0_req_ff.load_index;
      side1_in.vec        = {s0_req_ff.comp_vel_height, s0_req_ff.comp_vel_angle,
                             s0_req_ff.comp_vel_radius, s0_req_ff.comp_height,
                             s0_req_ff.comp_angle, s0_req_ff.comp_radius};
   end

   // ---------------------------------------------------------------------
   // Index division: |offset| / step
   // ---------------------------------------------------------------------
   logic                     d1_valid;
   logic [TIME_W-1:0]        d1_quo;
   logic [TIME_W-1:0]        d1_rem;
   logic [$bits(side1_type)-1:0] d1_side;
   side1_type                s1;

   tli_div #(
      .NUM_W  (TIME_W),
      .DEN_W  (TIME_W),
      .SIDE_W ($bits(side1_type))
   ) u_index_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .den       (step_eff_ff),
      .in_valid  (s0_valid_ff),
      .in_num    (side1_in.dmag),
      .in_side   (side1_in),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_rem   (d1_rem),
      .out_side  (d1_side)
   );

   assign s1 = side1_type'(d1_side);

   // ---------------------------------------------------------------------
   // Index clamp and offset within the chosen segment
   // ---------------------------------------------------------------------
   logic              a_valid_ff;
   side2_type         a_side_ff;
   logic [TIME_W-1:0] a_rmag_ff;
   side2_type         a_side_in;
   logic [TIME_W-1:0] a_rmag_in;
   logic              past_end;

   always_comb begin
      past_end             = d1_quo > TIME_W'(hiidx_ff);
      a_side_in.op         = s1.op;
      a_side_in.wneg       = s1.neg;
      a_side_in.load_index = s1.load_index;
      a_side_in.vec        = s1.vec;
      if (s1.neg) begin
         // before start: first segment, clamped once a full step back
         a_side_in.idx     = '0;
         a_side_in.clamped = (d1_quo != '0);
         a_rmag_in         = s1.dmag;
      end else if (past_end) begin
         a_side_in.idx     = hiidx_ff;
         a_side_in.clamped = 1'b1;
         a_rmag_in         = s1.dmag - hi_base_ff;
      end else begin
         a_side_in.idx     = d1_quo[IDX_W-1:0];
         a_side_in.clamped = 1'b0;
         a_rmag_in         = d1_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff <= a_side_in;
         a_rmag_ff <= a_rmag_in;
      end
   end

   // Weight numerator with half a step for rounding
   logic            b_valid_ff;
   side2_type       b_side_ff;
   logic [WM_W-1:0] b_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_side_ff <= a_side_ff;
         b_num_ff  <= WM_W'({a_rmag_ff, {WF{1'b0}}}) + WM_W'(step_eff_ff >> 1);
      end
   end

   // ---------------------------------------------------------------------
   // Weight division: rounded fraction of the step
   // ---------------------------------------------------------------------
   logic                         d2_valid;
   logic [WM_W-1:0]              d2_quo;
   logic [$bits(side2_type)-1:0] d2_side;
   side2_type                    s2;

   tli_div #(
      .NUM_W  (WM_W),
      .DEN_W  (TIME_W),
      .SIDE_W ($bits(side2_type))
   ) u_weight_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .den       (step_eff_ff),
      .in_valid  (b_valid_ff),
      .in_num    (b_num_ff),
      .in_side   (b_side_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_rem   (),
      .out_side  (d2_side)
   );

   assign s2 = side2_type'(d2_side);

   // ---------------------------------------------------------------------
   // Vector table: loads write, queries read both segment ends
   // ---------------------------------------------------------------------
   vec_type          table_mem [TABLE_DEPTH];
   vec_type          rd_lo_ff;
   vec_type          rd_hi_ff;
   logic [31:0]      load_idx32;
   logic             tbl_we;
   logic [IDX_W-1:0] tbl_widx;
   logic [IDX_W-1:0] tbl_ridx_hi;

   assign load_idx32  = 32'(s2.load_index);
   assign tbl_widx    = load_idx32[IDX_W-1:0];
   assign tbl_we      = adv && d2_valid && (s2.op == OP_LOAD)
                        && (load_idx32 < 32'(TABLE_DEPTH));
   assign tbl_ridx_hi = s2.idx + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (adv) begin
         if (tbl_we) begin
            table_mem[tbl_widx] <= s2.vec;
         end
         rd_lo_ff <= table_mem[s2.idx];
         rd_hi_ff <= table_mem[tbl_ridx_hi];
      end
   end

   logic            m_valid_ff;
   logic            m_clamped_ff;
   logic            m_wneg_ff;
   logic [WM_W-1:0] m_wmag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= d2_valid && (s2.op == OP_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_clamped_ff <= s2.clamped;
         m_wneg_ff    <= s2.wneg;
         m_wmag_ff    <= d2_quo;
      end
   end

   // ---------------------------------------------------------------------
   // Blend, stage 1: segment delta as sign and magnitude
   // ---------------------------------------------------------------------
   logic                 e1_valid_ff;
   logic                 e1_clamped_ff;
   logic [WM_W-1:0]      e1_wmag_ff;
   logic [CW-1:0]        e1_dmag_ff [NUM_COMPS];
   logic [NUM_COMPS-1:0] e1_neg_ff;
   logic [CW-1:0]        e1_lo_ff   [NUM_COMPS];
   logic [CW:0]          up_minus_lo [NUM_COMPS];
   logic [CW-1:0]        lo_minus_up [NUM_COMPS];

   always_comb begin
      for (int k = 0; k < NUM_COMPS; k++) begin
         up_minus_lo[k] = {rd_hi_ff[k][CW-1], rd_hi_ff[k]} - {rd_lo_ff[k][CW-1], rd_lo_ff[k]};
         lo_minus_up[k] = rd_lo_ff[k] - rd_hi_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_clamped_ff <= m_clamped_ff;
         e1_wmag_ff    <= m_wmag_ff;
         for (int k = 0; k < NUM_COMPS; k++) begin
            e1_dmag_ff[k] <= up_minus_lo[k][CW] ? lo_minus_up[k] : up_minus_lo[k][CW-1:0];
            e1_neg_ff[k]  <= up_minus_lo[k][CW] ^ m_wneg_ff;
            e1_lo_ff[k]   <= rd_lo_ff[k];
         end
      end
   end

   // Blend, stage 2: delta times weight as two partial products
   logic                 e2_valid_ff;
   logic                 e2_clamped_ff;
   logic [CW+WL_W-1:0]   e2_p0_ff [NUM_COMPS];
   logic [CW+WH_W-1:0]   e2_p1_ff [NUM_COMPS];
   logic [NUM_COMPS-1:0] e2_neg_ff;
   logic [CW-1:0]        e2_lo_ff [NUM_COMPS];
   logic [CW+WL_W-1:0]   p0_in    [NUM_COMPS];
   logic [CW+WH_W-1:0]   p1_in    [NUM_COMPS];
   logic [WL_W-1:0]      w_low;
   logic [WH_W-1:0]      w_high;

   assign w_low  = e1_wmag_ff[WL_W-1:0];
   assign w_high = e1_wmag_ff[WM_W-1:WL_W];

   always_comb begin
      for (int k = 0; k < NUM_COMPS; k++) begin
         p0_in[k] = e1_dmag_ff[k] * w_low;
         p1_in[k] = e1_dmag_ff[k] * w_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (adv) begin
         e2_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e2_clamped_ff <= e1_clamped_ff;
         e2_neg_ff     <= e1_neg_ff;
         for (int k = 0; k < NUM_COMPS; k++) begin
            e2_p0_ff[k] <= p0_in[k];
            e2_p1_ff[k] <= p1_in[k];
            e2_lo_ff[k] <= e1_lo_ff[k];
         end
      end
   end

   // Blend, stage 3: combine partials, round, drop the fraction
   logic                 e3_valid_ff;
   logic                 e3_clamped_ff;
   logic [MR_W-1:0]      e3_mr_ff [NUM_COMPS];
   logic [NUM_COMPS-1:0] e3_neg_ff;
   logic [CW-1:0]        e3_lo_ff [NUM_COMPS];
   logic [PROD_W-1:0]    prod_sum [NUM_COMPS];

   always_comb begin
      for (int k = 0; k < NUM_COMPS; k++) begin
         prod_sum[k] = PROD_W'(e2_p0_ff[k]) + (PROD_W'(e2_p1_ff[k]) << WL_W) + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e3_valid_ff <= 1'b0;
      end else if (adv) begin
         e3_valid_ff <= e2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e3_clamped_ff <= e2_clamped_ff;
         e3_neg_ff     <= e2_neg_ff;
         for (int k = 0; k < NUM_COMPS; k++) begin
            e3_mr_ff[k] <= prod_sum[k][PROD_W-1:WF];
            e3_lo_ff[k] <= e2_lo_ff[k];
         end
      end
   end

   // Blend, stage 4: apply the signed delta to the lower entry
   logic                 e4_valid_ff;
   logic                 e4_clamped_ff;
   logic [SUM_W-1:0]     e4_sum_ff [NUM_COMPS];
   logic [NUM_COMPS-1:0] e4_big_ff;
   logic [NUM_COMPS-1:0] e4_neg_ff;
   logic [SUM_W-1:0]     lo_ext [NUM_COMPS];
   logic [SUM_W-1:0]     mr_ext [NUM_COMPS];

   always_comb begin
      for (int k = 0; k < NUM_COMPS; k++) begin
         lo_ext[k] = {{(SUM_W-CW){e3_lo_ff[k][CW-1]}}, e3_lo_ff[k]};
         mr_ext[k] = SUM_W'(e3_mr_ff[k][CW:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e4_valid_ff <= 1'b0;
      end else if (adv) begin
         e4_valid_ff <= e3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e4_clamped_ff <= e3_clamped_ff;
         e4_neg_ff     <= e3_neg_ff;
         for (int k = 0; k < NUM_COMPS; k++) begin
            e4_big_ff[k] <= |e3_mr_ff[k][MR_W-1:CW+1];
            e4_sum_ff[k] <= e3_neg_ff[k] ? (lo_ext[k] - mr_ext[k]) : (lo_ext[k] + mr_ext[k]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Saturation and result register
   // ---------------------------------------------------------------------
   logic [CW-1:0] sat [NUM_COMPS];
   rsp_type       rsp_in;
   rsp_type       rsp_data_ff;

   always_comb begin
      for (int k = 0; k < NUM_COMPS; k++) begin
         if (e4_big_ff[k]) begin
            sat[k] = e4_neg_ff[k] ? C_MIN : C_MAX;
         end else if ($signed(e4_sum_ff[k]) > $signed(SUM_MAX)) begin
            sat[k] = C_MAX;
         end else if ($signed(e4_sum_ff[k]) < $signed(SUM_MIN)) begin
            sat[k] = C_MIN;
         end else begin
            sat[k] = e4_sum_ff[k][CW-1:0];
         end
      end
      rsp_in.out_radius     = sat[0];
      rsp_in.out_angle      = sat[1];
      rsp_in.out_height     = sat[2];
      rsp_in.out_vel_radius = sat[3];
      rsp_in.out_vel_angle  = sat[4];
      rsp_in.out_vel_height = sat[5];
      rsp_in.index_clamped  = e4_clamped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= e4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
